// ===== src/aes_pkg.sv =====
package aes_pkg;

	localparam int BlockW    = 128;
	localparam int WordW     = 32;
	localparam int NumRk     = 44;
	localparam int RkEntries = NumRk / 4;
	localparam int RkIdxW    = 6;
	localparam int RndW      = 4;

	typedef enum logic [0:0] {
		FUNC_ENC = 1'b0,
		FUNC_DEC = 1'b1
	} func_t;

	typedef enum logic [0:0] {
		REG_KEY_HIGH = 1'b0,
		REG_KEY_LOW  = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXPAND,
		ST_LOAD,
		ST_ROUND,
		ST_DONE
	} state_t;

	typedef logic [7:0] sbox_t [256];

	localparam sbox_t SBOX = '{
		8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
		8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
		8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
		8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
		8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
		8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
		8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
		8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
		8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
		8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
		8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
		8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
		8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
		8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
		8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
		8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
	};

	localparam sbox_t RSBOX = '{
		8'h52,8'h09,8'h6A,8'hD5,8'h30,8'h36,8'hA5,8'h38,8'hBF,8'h40,8'hA3,8'h9E,8'h81,8'hF3,8'hD7,8'hFB,
		8'h7C,8'hE3,8'h39,8'h82,8'h9B,8'h2F,8'hFF,8'h87,8'h34,8'h8E,8'h43,8'h44,8'hC4,8'hDE,8'hE9,8'hCB,
		8'h54,8'h7B,8'h94,8'h32,8'hA6,8'hC2,8'h23,8'h3D,8'hEE,8'h4C,8'h95,8'h0B,8'h42,8'hFA,8'hC3,8'h4E,
		8'h08,8'h2E,8'hA1,8'h66,8'h28,8'hD9,8'h24,8'hB2,8'h76,8'h5B,8'hA2,8'h49,8'h6D,8'h8B,8'hD1,8'h25,
		8'h72,8'hF8,8'hF6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hD4,8'hA4,8'h5C,8'hCC,8'h5D,8'h65,8'hB6,8'h92,
		8'h6C,8'h70,8'h48,8'h50,8'hFD,8'hED,8'hB9,8'hDA,8'h5E,8'h15,8'h46,8'h57,8'hA7,8'h8D,8'h9D,8'h84,
		8'h90,8'hD8,8'hAB,8'h00,8'h8C,8'hBC,8'hD3,8'h0A,8'hF7,8'hE4,8'h58,8'h05,8'hB8,8'hB3,8'h45,8'h06,
		8'hD0,8'h2C,8'h1E,8'h8F,8'hCA,8'h3F,8'h0F,8'h02,8'hC1,8'hAF,8'hBD,8'h03,8'h01,8'h13,8'h8A,8'h6B,
		8'h3A,8'h91,8'h11,8'h41,8'h4F,8'h67,8'hDC,8'hEA,8'h97,8'hF2,8'hCF,8'hCE,8'hF0,8'hB4,8'hE6,8'h73,
		8'h96,8'hAC,8'h74,8'h22,8'hE7,8'hAD,8'h35,8'h85,8'hE2,8'hF9,8'h37,8'hE8,8'h1C,8'h75,8'hDF,8'h6E,
		8'h47,8'hF1,8'h1A,8'h71,8'h1D,8'h29,8'hC5,8'h89,8'h6F,8'hB7,8'h62,8'h0E,8'hAA,8'h18,8'hBE,8'h1B,
		8'hFC,8'h56,8'h3E,8'h4B,8'hC6,8'hD2,8'h79,8'h20,8'h9A,8'hDB,8'hC0,8'hFE,8'h78,8'hCD,8'h5A,8'hF4,
		8'h1F,8'hDD,8'hA8,8'h33,8'h88,8'h07,8'hC7,8'h31,8'hB1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hEC,8'h5F,
		8'h60,8'h51,8'h7F,8'hA9,8'h19,8'hB5,8'h4A,8'h0D,8'h2D,8'hE5,8'h7A,8'h9F,8'h93,8'hC9,8'h9C,8'hEF,
		8'hA0,8'hE0,8'h3B,8'h4D,8'hAE,8'h2A,8'hF5,8'hB0,8'hC8,8'hEB,8'hBB,8'h3C,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2B,8'h04,8'h7E,8'hBA,8'h77,8'hD6,8'h26,8'hE1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0C,8'h7D
	};

	// Multiply by x in GF(2^8)
	function automatic logic [7:0] xt(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
	endfunction

	// Forward MixColumns on one column
	function automatic logic [31:0] mix_fwd(input logic [31:0] c);
		logic [7:0] a0, a1, a2, a3;
		a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
		return {xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3,
			a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3,
			a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3,
			xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3)};
	endfunction

	// Inverse MixColumns: premultiply by {04,00,05,00}, then forward mix
	function automatic logic [31:0] mix_inv(input logic [31:0] c);
		logic [7:0] a0, a1, a2, a3, u, v;
		a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
		u = xt(xt(a0 ^ a2));
		v = xt(xt(a1 ^ a3));
		return mix_fwd({a0 ^ u, a1 ^ v, a2 ^ u, a3 ^ v});
	endfunction

endpackage

// ===== src/aes128_block_cipher.sv =====
// After an item is accepted it passes a load step (initial key add) and 10 rounds,
// then the result is held until handed off. If the round keys are not ready after
// reset or a key write, key expansion of the remaining 40 words runs between accept and load.
// A new item is taken only once the previous result has been handed off; one shared round unit serves every round.
// Key expansion runs one word per cycle on its own four-byte S-box.
// arst_n clears control state and both key registers; round keys are rebuilt.
module aes128_block_cipher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_idx,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        func,
	input  logic [63:0] data_in_high,
	input  logic [63:0] data_in_low,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] data_out_high,
	output logic [63:0] data_out_low
);
	import aes_pkg::*;

	state_t state_q, state_d;
	logic [63:0] key_hi_q, key_lo_q;
	logic keys_ready_q;
	logic [RkIdxW-1:0] kidx_q;
	logic [RndW-1:0] rnd_q;
	logic dec_q;
	logic [BlockW-1:0] blk_q, blk_d;
	logic [WordW-1:0] w1_q, w2_q, w3_q, w4_q;
	logic [7:0] rcon_q;
	logic [BlockW-1:0] rk_mem [RkEntries];
	logic [BlockW-1:0] rk_q;
	logic [RndW-1:0] rd_idx;
	logic rd_dec, rk_bypass;
	logic [WordW-1:0] new_w, tw, sw;
	logic accept, round_last;

	assign accept     = in_valid && !in_stall;
	assign round_last = (rnd_q == RndW'(10));

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (accept) state_d = keys_ready_q ? ST_LOAD : ST_EXPAND;
			ST_EXPAND: if (kidx_q == RkIdxW'(NumRk - 1)) state_d = ST_LOAD;
			ST_LOAD:   state_d = ST_ROUND;
			ST_ROUND:  if (round_last) state_d = ST_DONE;
			ST_DONE:   if (!out_stall) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		in_stall  = (state_q != ST_IDLE);
		out_valid = (state_q == ST_DONE);
	end
	assign data_out_high = blk_q[127:64];
	assign data_out_low  = blk_q[63:0];

	// Key schedule word: w[i] = w[i-4] ^ f(w[i-1])
	always_comb begin
		tw = {w4_q[23:0], w4_q[31:24]};
		sw = {SBOX[tw[31:24]], SBOX[tw[23:16]], SBOX[tw[15:8]], SBOX[tw[7:0]]};
		if (kidx_q[1:0] == 2'd0) new_w = w1_q ^ sw ^ {rcon_q, 24'd0};
		else                      new_w = w1_q ^ w4_q;
	end

	// Round-key read index: round key needed in the next cycle
	always_comb begin
		rd_dec    = (state_q == ST_IDLE) ? (func_t'(func) == FUNC_DEC) : dec_q;
		// last round key is written in the final expansion cycle
		rk_bypass = (state_q == ST_EXPAND) && (kidx_q == RkIdxW'(NumRk - 1)) && dec_q;
		if ((state_q == ST_LOAD || state_q == ST_ROUND) && !round_last)
			rd_idx = dec_q ? RndW'(9) - rnd_q : rnd_q + RndW'(1);
		else
			rd_idx = rd_dec ? RndW'(10) : RndW'(0);
	end

	// Shared round unit
	always_comb begin
		logic [BlockW-1:0] sb, sr, mx, rk;
		logic [7:0] b [16];
		logic [7:0] t [16];
		rk = rk_q;
		sb = '0;
		mx = '0;
		for (int i = 0; i < 16; i++) b[i] = blk_q[127-8*i -: 8];
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++)
				t[c*4+r] = dec_q ? RSBOX[b[((c + 3*r) & 3)*4 + r]]
				                 : SBOX[b[((c + r) & 3)*4 + r]];
		for (int i = 0; i < 16; i++) sr[127-8*i -: 8] = t[i];
		blk_d = blk_q;
		if (state_q == ST_LOAD) begin
			blk_d = blk_q ^ rk;
		end else if (!dec_q) begin
			for (int c = 0; c < 4; c++) mx[127-32*c -: 32] = mix_fwd(sr[127-32*c -: 32]);
			sb = round_last ? sr : mx;
			blk_d = sb ^ rk;
		end else begin
			sb = sr ^ rk;
			for (int c = 0; c < 4; c++) mx[127-32*c -: 32] = mix_inv(sb[127-32*c -: 32]);
			blk_d = round_last ? sb : mx;
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			key_hi_q     <= '0;
			key_lo_q     <= '0;
			keys_ready_q <= 1'b0;
			kidx_q       <= '0;
			rnd_q        <= '0;
			dec_q        <= 1'b0;
			rcon_q       <= 8'h01;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (reg_idx_t'(cfg_idx))
					REG_KEY_HIGH: key_hi_q <= cfg_data;
					REG_KEY_LOW:  key_lo_q <= cfg_data;
					default: ;
				endcase
				keys_ready_q <= 1'b0;
			end
			if (accept) begin
				dec_q  <= (func_t'(func) == FUNC_DEC);
				kidx_q <= RkIdxW'(4);
				rcon_q <= 8'h01;
				rnd_q  <= '0;
			end
			if (state_q == ST_EXPAND) begin
				kidx_q <= kidx_q + RkIdxW'(1);
				if (kidx_q[1:0] == 2'd0) rcon_q <= xt(rcon_q);
				if (kidx_q == RkIdxW'(NumRk - 1)) keys_ready_q <= 1'b1;
			end
			if (state_q == ST_LOAD) rnd_q <= RndW'(1);
			else if (state_q == ST_ROUND) rnd_q <= rnd_q + RndW'(1);
		end
	end

	// Round-key memory (one round key per entry), key window and data path
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept && !keys_ready_q) begin
			rk_mem[0] <= {key_hi_q, key_lo_q};
			w1_q <= key_hi_q[63:32];
			w2_q <= key_hi_q[31:0];
			w3_q <= key_lo_q[63:32];
			w4_q <= key_lo_q[31:0];
		end
		if (state_q == ST_EXPAND) begin
			if (kidx_q[1:0] == 2'd3) rk_mem[kidx_q[5:2]] <= {w2_q, w3_q, w4_q, new_w};
			w1_q <= w2_q; w2_q <= w3_q; w3_q <= w4_q; w4_q <= new_w;
		end
		if (accept) blk_q <= {data_in_high, data_in_low};
		else if (state_q == ST_LOAD || state_q == ST_ROUND) blk_q <= blk_d;
		rk_q <= rk_bypass ? {w2_q, w3_q, w4_q, new_w} : rk_mem[rd_idx];
	end

endmodule

// ===== src/aes_checker.sv =====
module aes_props (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic [63:0] data_out_high
);
	// Never accept input while a result is pending
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input taken while result pending");

	// Result stays valid and its high half holds while stalled
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(data_out_high))
		else $error("result dropped under stall");

	// An accepted item blocks the input on the next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall) else $error("not busy after accept");

	// No result the cycle right after an accept
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> !out_valid) else $error("result too early");
endmodule

bind aes128_block_cipher aes_props u_aes_props (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .data_out_high(data_out_high)
);
